[rtl/core/kcl_pkg.sv]
`timescale 1ns / 1ps
// Package for the keypad code lock: payload structs, state codes, key codes
// and configuration register indexes. No dependencies.
package kcl_pkg;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_LOCKED   = 3'd1,
    ST_ENTERING = 3'd2,
    ST_OPEN     = 3'd3,
    ST_WRONG    = 3'd4,
    ST_LOCKOUT  = 3'd5,
    ST_ERROR    = 3'd6
  } lock_state_t;

  typedef enum logic [2:0] {
    CFG_PASSWORD_BCD  = 3'd0,
    CFG_MAX_ATTEMPTS  = 3'd1,
    CFG_OPEN_TICKS    = 3'd2,
    CFG_WRONG_TICKS   = 3'd3,
    CFG_ERROR_TICKS   = 3'd4,
    CFG_LOCKOUT_TICKS = 3'd5
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int PASSWORD_W  = 24;
  localparam int ATTEMPT_W   = 4;
  localparam int TIMER_W     = 16;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [7:0] KEY_0    = 8'h30;
  localparam logic [7:0] KEY_9    = 8'h39;
  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_C    = 8'h43;
  localparam logic [7:0] KEY_A    = 8'h41;

  localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = 4'd15;

  localparam logic [PASSWORD_W-1:0] RST_PASSWORD_BCD  = 24'h123456;
  localparam logic [ATTEMPT_W-1:0]  RST_MAX_ATTEMPTS  = 4'd3;
  localparam logic [TIMER_W-1:0]    RST_OPEN_TICKS    = 16'd50;
  localparam logic [TIMER_W-1:0]    RST_WRONG_TICKS   = 16'd20;
  localparam logic [TIMER_W-1:0]    RST_ERROR_TICKS   = 16'd20;
  localparam logic [TIMER_W-1:0]    RST_LOCKOUT_TICKS = 16'd500;

  typedef struct packed {
    logic       mode;
    logic [7:0] key_code;
  } kcl_in_t;

  typedef struct packed {
    logic [2:0] lock_state;
    logic       door_open;
    logic       door_event;
    logic [2:0] digits_entered;
    logic [3:0] failed_attempts;
  } kcl_out_t;

endpackage

[rtl/core/keypad_code_lock_unit.sv]
`timescale 1ns / 1ps
// Keypad code lock with attempt counting and timed lockout, top level.
// Depends on kcl_pkg for payload structs, state codes and key codes.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_ready    in_data  (kcl_pkg::kcl_in_t)
//   out       output     out_valid / out_ready  out_data (kcl_pkg::kcl_out_t)
//   cfg       input      cfg_we                 cfg_index, cfg_data
//
// For every transaction on the input, the state registers update at the accepting
// edge and the result register is loaded at the same edge.
// The result register is refilled in the cycle it is taken, so one item a cycle while the output is not stalled.
// Synchronous reset returns the lock to idle and the registers to their defaults.
// A stalled output blocks new input until the waiting result is taken.
module keypad_code_lock_unit #(
  parameter int CODE_DIGITS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kcl_pkg::kcl_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kcl_pkg::kcl_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int PW_W  = 4 * CODE_DIGITS;

  // Configuration registers.
  logic [kcl_pkg::PASSWORD_W-1:0] password_bcd;
  logic [kcl_pkg::ATTEMPT_W-1:0]  max_attempts;
  logic [kcl_pkg::TIMER_W-1:0]    open_ticks;
  logic [kcl_pkg::TIMER_W-1:0]    wrong_ticks;
  logic [kcl_pkg::TIMER_W-1:0]    error_ticks;
  logic [kcl_pkg::TIMER_W-1:0]    lockout_ticks;

  // Lock state.
  kcl_pkg::lock_state_t           state, state_next;
  logic [3:0]                     entry_digits [CODE_DIGITS];
  logic [3:0]                     entry_digits_next [CODE_DIGITS];
  logic [CNT_W-1:0]               entry_count, entry_count_next;
  logic [kcl_pkg::ATTEMPT_W-1:0]  attempt_count, attempt_count_next;
  logic [kcl_pkg::TIMER_W-1:0]    wait_timer, wait_timer_next;
  logic                           door_flag, door_flag_next;
  logic                           door_event_next;

  kcl_pkg::kcl_out_t              result_next;
  logic                           in_fire;
  logic                           is_tick;
  logic                           is_digit;
  logic [3:0]                     digit_val;
  logic                           entry_full;
  logic                           code_ok;
  logic [PW_W-1:0]                pw_ext;
  logic [kcl_pkg::TIMER_W-1:0]    timer_dec;
  logic [kcl_pkg::ATTEMPT_W-1:0]  attempt_inc;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      password_bcd  <= kcl_pkg::RST_PASSWORD_BCD;
      max_attempts  <= kcl_pkg::RST_MAX_ATTEMPTS;
      open_ticks    <= kcl_pkg::RST_OPEN_TICKS;
      wrong_ticks   <= kcl_pkg::RST_WRONG_TICKS;
      error_ticks   <= kcl_pkg::RST_ERROR_TICKS;
      lockout_ticks <= kcl_pkg::RST_LOCKOUT_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        kcl_pkg::CFG_PASSWORD_BCD:  password_bcd  <= cfg_data[kcl_pkg::PASSWORD_W-1:0];
        kcl_pkg::CFG_MAX_ATTEMPTS:  max_attempts  <= cfg_data[kcl_pkg::ATTEMPT_W-1:0];
        kcl_pkg::CFG_OPEN_TICKS:    open_ticks    <= cfg_data[kcl_pkg::TIMER_W-1:0];
        kcl_pkg::CFG_WRONG_TICKS:   wrong_ticks   <= cfg_data[kcl_pkg::TIMER_W-1:0];
        kcl_pkg::CFG_ERROR_TICKS:   error_ticks   <= cfg_data[kcl_pkg::TIMER_W-1:0];
        kcl_pkg::CFG_LOCKOUT_TICKS: lockout_ticks <= cfg_data[kcl_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  assign is_tick    = (in_data.mode == kcl_pkg::MODE_TICK);
  assign is_digit   = (in_data.key_code >= kcl_pkg::KEY_0) &&
                      (in_data.key_code <= kcl_pkg::KEY_9);
  assign digit_val  = 4'(in_data.key_code - kcl_pkg::KEY_0);
  assign entry_full = (entry_count == CNT_W'(CODE_DIGITS));
  assign timer_dec  = (wait_timer != '0) ? wait_timer - 1'b1 : wait_timer;
  assign attempt_inc = (attempt_count < kcl_pkg::ATTEMPT_MAX) ?
                       attempt_count + 1'b1 : attempt_count;

  // Code digits beyond the register width read as zero.
  assign pw_ext = PW_W'(password_bcd);

  always_comb begin
    code_ok = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entry_digits[i] != pw_ext[4*(CODE_DIGITS-1-i) +: 4]) begin
        code_ok = 1'b0;
      end
    end
  end

  // Next-state and datapath update for one transaction.
  always_comb begin
    state_next         = state;
    entry_digits_next  = entry_digits;
    entry_count_next   = entry_count;
    attempt_count_next = attempt_count;
    wait_timer_next    = wait_timer;
    door_flag_next     = door_flag;
    door_event_next    = 1'b0;
    if (is_tick) begin
      if (state == kcl_pkg::ST_OPEN || state == kcl_pkg::ST_WRONG ||
          state == kcl_pkg::ST_LOCKOUT || state == kcl_pkg::ST_ERROR) begin
        wait_timer_next = timer_dec;
        if (timer_dec == '0) begin
          case (state)
            kcl_pkg::ST_OPEN: begin
              door_flag_next  = 1'b0;
              door_event_next = 1'b1;
              state_next      = kcl_pkg::ST_LOCKED;
            end
            kcl_pkg::ST_ERROR: begin
              state_next         = kcl_pkg::ST_LOCKOUT;
              wait_timer_next    = lockout_ticks;
              attempt_count_next = '0;
            end
            default: state_next = kcl_pkg::ST_LOCKED;
          endcase
        end
      end
    end else begin
      case (state)
        kcl_pkg::ST_IDLE: begin
          if (in_data.key_code == kcl_pkg::KEY_C) begin
            state_next = kcl_pkg::ST_LOCKED;
          end
        end
        kcl_pkg::ST_LOCKED: begin
          if (is_digit) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              entry_digits_next[i] = '0;
            end
            entry_digits_next[0] = digit_val;
            entry_count_next     = CNT_W'(1);
            state_next           = kcl_pkg::ST_ENTERING;
          end else if (in_data.key_code == kcl_pkg::KEY_C) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              entry_digits_next[i] = '0;
            end
            entry_count_next = '0;
            state_next       = kcl_pkg::ST_IDLE;
          end else if (in_data.key_code == kcl_pkg::KEY_A) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              entry_digits_next[i] = '0;
            end
            entry_count_next = '0;
            state_next       = kcl_pkg::ST_ERROR;
            wait_timer_next  = error_ticks;
          end
        end
        kcl_pkg::ST_ENTERING: begin
          if (is_digit && !entry_full) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              if (entry_count == CNT_W'(i)) begin
                entry_digits_next[i] = digit_val;
              end
            end
            entry_count_next = entry_count + 1'b1;
          end else if (in_data.key_code == kcl_pkg::KEY_HASH && entry_full) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              entry_digits_next[i] = '0;
            end
            entry_count_next = '0;
            if (code_ok) begin
              attempt_count_next = '0;
              state_next         = kcl_pkg::ST_OPEN;
              wait_timer_next    = open_ticks;
              door_flag_next     = 1'b1;
              door_event_next    = 1'b1;
            end else if (attempt_inc >= max_attempts) begin
              state_next         = kcl_pkg::ST_LOCKOUT;
              wait_timer_next    = lockout_ticks;
              attempt_count_next = '0;
            end else begin
              attempt_count_next = attempt_inc;
              state_next         = kcl_pkg::ST_WRONG;
              wait_timer_next    = wrong_ticks;
            end
          end else if (in_data.key_code == kcl_pkg::KEY_STAR) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              entry_digits_next[i] = '0;
            end
            entry_count_next = '0;
            state_next       = kcl_pkg::ST_LOCKED;
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields are the values after the transaction.
  always_comb begin
    result_next.lock_state      = state_next;
    result_next.door_open       = door_flag_next;
    result_next.door_event      = door_event_next;
    result_next.digits_entered  = 3'(entry_count_next);
    result_next.failed_attempts = attempt_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= kcl_pkg::ST_IDLE;
      entry_count   <= '0;
      attempt_count <= '0;
      wait_timer    <= '0;
      door_flag     <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        entry_digits[i] <= '0;
      end
    end else if (in_fire) begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      attempt_count <= attempt_count_next;
      wait_timer    <= wait_timer_next;
      door_flag     <= door_flag_next;
      entry_digits  <= entry_digits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result_next;
    end
  end

`ifndef SYNTHESIS
  // The door is released exactly while the lock reports the open state.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.door_open ==
                   (out_data.lock_state == kcl_pkg::ST_OPEN)))
    else $error("door_open disagrees with the open state");

  // Only code entry holds digits in the buffer.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.lock_state != kcl_pkg::ST_ENTERING) |->
      (out_data.digits_entered == 3'd0))
    else $error("digits held outside of code entry");

  // Every accepted transaction produces a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted transaction produced no result");
`endif

endmodule

[tb/sv/kcl_lock_checker.sv]
`timescale 1ns / 1ps
// Checker for keypad_code_lock_unit: follows the configuration writes, predicts one
// status result per accepted input transaction and compares it with the output channel.
// Depends on kcl_pkg for the payload structs, state codes, key codes and register indexes.
module kcl_lock_checker #(
  parameter int CODE_DIGITS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  kcl_pkg::kcl_in_t                     in_data,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  kcl_pkg::kcl_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                   fail_count,
  output int                                   results_due,
  output kcl_pkg::lock_state_t                 lock_state_now
);
  import kcl_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Configuration as the block should hold it.
  logic [PASSWORD_W-1:0] code_reg;
  logic [ATTEMPT_W-1:0]  attempt_limit;
  logic [TIMER_W-1:0]    open_len;
  logic [TIMER_W-1:0]    wrong_len;
  logic [TIMER_W-1:0]    error_len;
  logic [TIMER_W-1:0]    lockout_len;

  // Lock state as the block should hold it.
  lock_state_t           state_q;
  logic [3:0]            entry [CODE_DIGITS];
  int                    entry_len;
  logic [ATTEMPT_W-1:0]  misses;
  logic [TIMER_W-1:0]    countdown;
  logic                  door;

  kcl_out_t              status_due [$];
  int                    mismatches = 0;

  function automatic void clear_entry();
    int i;
    for (i = 0; i < CODE_DIGITS; i++) entry[i] = 4'd0;
    entry_len = 0;
  endfunction

  function automatic void restart_lock();
    code_reg      = RST_PASSWORD_BCD;
    attempt_limit = RST_MAX_ATTEMPTS;
    open_len      = RST_OPEN_TICKS;
    wrong_len     = RST_WRONG_TICKS;
    error_len     = RST_ERROR_TICKS;
    lockout_len   = RST_LOCKOUT_TICKS;
    state_q       = ST_IDLE;
    clear_entry();
    misses        = '0;
    countdown     = '0;
    door          = 1'b0;
  endfunction

  function automatic void enter_lockout();
    state_q   = ST_LOCKOUT;
    countdown = lockout_len;
    misses    = '0;
  endfunction

  // Digit i of the entry is compared with nibble CODE_DIGITS-1-i of the code;
  // nibbles above the register width read as zero.
  function automatic bit code_hit();
    logic [63:0] wide;
    logic [3:0]  nib;
    int i;
    wide = {{(64 - PASSWORD_W){1'b0}}, code_reg};
    for (i = 0; i < CODE_DIGITS; i++) begin
      nib = 4'((wide >> (4 * (CODE_DIGITS - 1 - i))) & 64'hF);
      if (nib != entry[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic kcl_out_t lock_step(input kcl_in_t item);
    kcl_out_t res;
    logic     ev;
    logic     is_digit;
    logic     hit;
    ev = 1'b0;
    if (item.mode == MODE_TICK) begin
      if (state_q == ST_OPEN || state_q == ST_WRONG || state_q == ST_LOCKOUT ||
          state_q == ST_ERROR) begin
        if (countdown != 0) countdown--;
        if (countdown == 0) begin
          case (state_q)
            ST_OPEN: begin
              door    = 1'b0;
              ev      = 1'b1;
              state_q = ST_LOCKED;
            end
            ST_ERROR: enter_lockout();
            default: state_q = ST_LOCKED;
          endcase
        end
      end
    end else begin
      is_digit = (item.key_code >= KEY_0) && (item.key_code <= KEY_9);
      case (state_q)
        ST_IDLE: begin
          if (item.key_code == KEY_C) state_q = ST_LOCKED;
        end
        ST_LOCKED: begin
          if (is_digit) begin
            clear_entry();
            entry[0]  = 4'(item.key_code - KEY_0);
            entry_len = 1;
            state_q   = ST_ENTERING;
          end else if (item.key_code == KEY_C) begin
            clear_entry();
            state_q = ST_IDLE;
          end else if (item.key_code == KEY_A) begin
            clear_entry();
            state_q   = ST_ERROR;
            countdown = error_len;
          end
        end
        ST_ENTERING: begin
          if (is_digit && entry_len < CODE_DIGITS) begin
            entry[entry_len] = 4'(item.key_code - KEY_0);
            entry_len++;
          end else if (item.key_code == KEY_HASH && entry_len == CODE_DIGITS) begin
            hit = code_hit();
            clear_entry();
            if (hit) begin
              misses    = '0;
              state_q   = ST_OPEN;
              countdown = open_len;
              door      = 1'b1;
              ev        = 1'b1;
            end else begin
              if (misses < ATTEMPT_MAX) misses++;
              if (misses >= attempt_limit) begin
                enter_lockout();
              end else begin
                state_q   = ST_WRONG;
                countdown = wrong_len;
              end
            end
          end else if (item.key_code == KEY_STAR) begin
            clear_entry();
            state_q = ST_LOCKED;
          end
        end
        default: ;
      endcase
    end
    res.lock_state      = state_q;
    res.door_open       = door;
    res.door_event      = ev;
    res.digits_entered  = 3'(entry_len);
    res.failed_attempts = misses;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    kcl_out_t want;
    if (rst) begin
      restart_lock();
      status_due.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PASSWORD_BCD:  code_reg      = cfg_data[PASSWORD_W-1:0];
          CFG_MAX_ATTEMPTS:  attempt_limit = cfg_data[ATTEMPT_W-1:0];
          CFG_OPEN_TICKS:    open_len      = cfg_data[TIMER_W-1:0];
          CFG_WRONG_TICKS:   wrong_len     = cfg_data[TIMER_W-1:0];
          CFG_ERROR_TICKS:   error_len     = cfg_data[TIMER_W-1:0];
          CFG_LOCKOUT_TICKS: lockout_len   = cfg_data[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result transaction with none expected: %h", $time, out_data);
        end else begin
          want = status_due.pop_front();
          check_field("lock_state", want.lock_state, out_data.lock_state);
          check_field("door_open", want.door_open, out_data.door_open);
          check_field("door_event", want.door_event, out_data.door_event);
          check_field("digits_entered", want.digits_entered, out_data.digits_entered);
          check_field("failed_attempts", want.failed_attempts, out_data.failed_attempts);
        end
      end
      if (in_valid === 1'b1 && in_ready === 1'b1) status_due.push_back(lock_step(in_data));
    end
    fail_count     <= mismatches;
    results_due    <= status_due.size();
    lock_state_now <= state_q;
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for keypad_code_lock_unit: clock, reset, key and tick stimulus over
// several register settings, and the verdict. Depends on kcl_pkg and kcl_lock_checker.
module tb_top;
  import kcl_pkg::*;

  localparam int CODE_DIGITS = 6;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  kcl_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  kcl_out_t               out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int                     fail_count;
  int                     results_due;
  lock_state_t            lock_state_now;

  int                     items_sent = 0;
  bit                     tx_steady = 1'b0;
  bit                     rx_steady = 1'b0;
  int                     rx_hold_req = 0;
  int                     tick_span = 4;
  logic [PASSWORD_W-1:0]  code_now = RST_PASSWORD_BCD;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keypad_code_lock_unit #(.CODE_DIGITS(CODE_DIGITS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kcl_lock_checker #(.CODE_DIGITS(CODE_DIGITS)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .results_due    (results_due),
    .lock_state_now (lock_state_now)
  );

  // Takes one result transaction per pass; a requested hold-off replaces the
  // random stall once.
  initial begin : result_sink
    int stall;
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 15);
      if (rx_hold_req > 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_item(input logic mode, input logic [7:0] code);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, key_code: code};
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  task automatic press(input logic [7:0] code);
    send_item(MODE_KEY, code);
  endtask

  // The key field of a tick carries random bits that the lock must ignore.
  task automatic tick();
    send_item(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] stray_key();
    case ($urandom_range(0, 5))
      0: return KEY_C;
      1: return KEY_A;
      2: return KEY_HASH;
      3: return KEY_STAR;
      4: return KEY_0 + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic noise();
    if ($urandom_range(0, 2) == 0) tick();
    else press(stray_key());
  endtask

  // The predicted state is read from the checker's registered copy after the last accepted transaction.
  task automatic read_state(output lock_state_t s);
    in_valid <= 1'b0;
    @(posedge clk);
    s = lock_state_now;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [PASSWORD_W-1:0] pw, input logic [ATTEMPT_W-1:0] att,
                               input logic [TIMER_W-1:0] op, input logic [TIMER_W-1:0] wr,
                               input logic [TIMER_W-1:0] er, input logic [TIMER_W-1:0] lo);
    int t;
    wait_results_drained();
    write_reg(CFG_PASSWORD_BCD, pw);
    write_reg(CFG_MAX_ATTEMPTS, att);
    write_reg(CFG_OPEN_TICKS, op);
    write_reg(CFG_WRONG_TICKS, wr);
    write_reg(CFG_ERROR_TICKS, er);
    write_reg(CFG_LOCKOUT_TICKS, lo);
    cfg_we <= 1'b0;
    code_now = pw;
    t = op;
    if (wr > t) t = wr;
    if (int'(er) + int'(lo) > t) t = int'(er) + int'(lo);
    if (t > 24) t = 24;
    tick_span = t + 1;
  endtask

  function automatic logic [PASSWORD_W-1:0] random_code();
    logic [PASSWORD_W-1:0] v;
    int i;
    if ($urandom_range(0, 4) == 0) return PASSWORD_W'($urandom());
    for (i = 0; i < CODE_DIGITS; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  // Half the attempts use the configured code, the rest have one digit redrawn.
  task automatic try_code();
    logic [3:0] digit [CODE_DIGITS];
    int i;
    int bad;
    for (i = 0; i < CODE_DIGITS; i++) digit[i] = code_now[4*(CODE_DIGITS-1-i) +: 4];
    if ($urandom_range(0, 1) == 1) begin
      bad = $urandom_range(0, CODE_DIGITS - 1);
      digit[bad] = 4'($urandom_range(0, 9));
    end
    for (i = 0; i < CODE_DIGITS; i++) begin
      if ($urandom_range(0, 19) == 0) press(KEY_HASH);
      press(KEY_0 + 8'(digit[i]));
      if ($urandom_range(0, 39) == 0) begin
        press(KEY_STAR);
        return;
      end
    end
    if ($urandom_range(0, 4) == 0) press(KEY_0 + 8'($urandom_range(0, 9)));
    press(KEY_HASH);
  endtask

  task automatic run_sessions(input int upto);
    lock_state_t s;
    int r;
    int n;
    while (items_sent < upto) begin
      read_state(s);
      r = $urandom_range(0, 99);
      case (s)
        ST_IDLE: begin
          if (r < 85) press(KEY_C);
          else noise();
        end
        ST_LOCKED: begin
          if (r < 70) try_code();
          else if (r < 78) press(KEY_A);
          else if (r < 86) press(KEY_C);
          else noise();
        end
        ST_ENTERING: begin
          if (r < 40) begin
            press(KEY_STAR);
          end else if (r < 75) begin
            n = $urandom_range(1, CODE_DIGITS);
            repeat (n) press(KEY_0 + 8'($urandom_range(0, 9)));
            press(KEY_HASH);
          end else begin
            noise();
          end
        end
        default: begin
          n = $urandom_range(1, tick_span);
          repeat (n) begin
            if ($urandom_range(0, 6) == 0) press(stray_key());
            else tick();
          end
        end
      endcase
    end
  endtask

  task automatic settle_to_locked();
    lock_state_t s;
    read_state(s);
    while (s != ST_LOCKED) begin
      case (s)
        ST_IDLE:     press(KEY_C);
        ST_ENTERING: press(KEY_STAR);
        default:     tick();
      endcase
      read_state(s);
    end
  endtask

  initial begin : stimulus
    int i;
    int p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk through every state but the wrong-code state, with short timers.
    load_settings(24'h123456, 4'd2, 16'd2, 16'd2, 16'd2, 16'd3);
    tick();
    press(KEY_A);
    press(8'h00);
    press(8'hFF);
    press(KEY_C);
    tick();
    press(KEY_0);
    press(KEY_HASH);
    press(KEY_STAR);
    for (i = 1; i <= CODE_DIGITS; i++) press(KEY_0 + 8'(i));
    press(KEY_9);
    press(KEY_HASH);
    press(KEY_0 + 8'd5);
    tick();
    tick();
    press(KEY_A);
    repeat (5) tick();
    press(KEY_C);

    // Shortest timers with no idling on either side.
    load_settings(24'h000000, 4'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_sessions(items_sent + 120);

    load_settings(24'h999999, 4'd15, 16'd3, 16'd2, 16'd4, 16'd5);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    run_sessions(items_sent + 120);

    // Attempt limit of zero and timers loaded with zero.
    load_settings(random_code(), 4'd0, 16'd0, 16'd2, 16'd0, 16'd2);
    run_sessions(items_sent + 120);

    // Nibbles above nine can never match.
    load_settings(24'hFFFFFF, 4'd2, 16'd2, 16'd3, 16'd1, 16'd2);
    run_sessions(items_sent + 100);

    // The receiver holds off while the sender streams, then the sender waits
    // for every result before going on.
    load_settings(random_code(), 4'd3, 16'd3, 16'd2, 16'd2, 16'd4);
    rx_hold_req = 80;
    tx_steady = 1'b1;
    run_sessions(items_sent + 40);
    wait_results_drained();
    tx_steady = 1'b0;
    run_sessions(items_sent + 90);

    for (p = 0; p < 4; p++) begin
      load_settings(random_code(), 4'($urandom_range(0, 15)), 16'($urandom_range(1, 6)),
                    16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                    16'($urandom_range(1, 6)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      run_sessions(items_sent + 110);
    end

    // Longest timers last, since the door then stays open to the end.
    load_settings(24'h907135, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    settle_to_locked();
    for (i = 0; i < CODE_DIGITS; i++) press(KEY_0 + 8'(code_now[4*(CODE_DIGITS-1-i) +: 4]));
    press(KEY_HASH);
    repeat (40) noise();

    wait_results_drained();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && results_due == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
